[sv/dbc_pkg.sv]
// Shared types, constants and the digit decode table for the debounced button counter.
package dbc_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int HIST_W      = 16;
   localparam int COUNT_W     = 10;
   localparam int SEG_W       = 8;

   typedef logic [HIST_W-1:0]      hist_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [SEG_W-1:0]       seg_type;
   typedef logic [NUM_BUTTONS-1:0] fire_type;
   typedef logic [3:0]             digit_type;

   localparam hist_type HIST_FORCE = 16'hE000;
   localparam hist_type HIST_FIRE  = 16'hF000;
   localparam seg_type  SEG_BLANK  = 8'hFF;

   // Decoded display word for one count value.
   typedef struct packed {
      count_type count;
      seg_type   ones;
      seg_type   tens;
      seg_type   colon;
      seg_type   hundreds;
      seg_type   thousands;
   } disp_type;

   // Active-low segment code: bit 0 is segment a, bit 7 the point.
   function automatic seg_type digit_code(input digit_type d);
      seg_type s;
      case (d)
         4'd0: s = 8'hC0;
         4'd1: s = 8'hF9;
         4'd2: s = 8'hA4;
         4'd3: s = 8'hB0;
         4'd4: s = 8'h99;
         4'd5: s = 8'h92;
         4'd6: s = 8'h82;
         4'd7: s = 8'hF8;
         4'd8: s = 8'h80;
         4'd9: s = 8'h90;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

[sv/dbc_lane.sv]
// One button lane: shift-register debounce history and the single-shot press detect.
module dbc_lane (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic level,
   output logic fire
);
   import dbc_pkg::*;

   hist_type history_ff;
   hist_type history_in;

   always_comb begin
      history_in = {history_ff[HIST_W-2:0], level} | HIST_FORCE;
      fire       = (history_in == HIST_FIRE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (load) begin
         history_ff <= history_in;
      end
   end

endmodule

[sv/dbc_merge.sv]
// Merge stage: adds the weights of all firing lanes to the running count, clearing it to zero on overflow.
module dbc_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dbc_pkg::fire_type fires,
   output dbc_pkg::count_type count
);
   import dbc_pkg::*;

   count_type          count_ff;
   count_type          count_in;
   logic [COUNT_W:0]   sum;

   // Lane i weighs 2^i, so the fire vector read as a number is the whole increment.
   always_comb begin
      sum      = {1'b0, count_ff} + {{(COUNT_W + 1 - NUM_BUTTONS){1'b0}}, fires};
      count_in = sum[COUNT_W] ? '0 : sum[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

[sv/dbc_seg.sv]
// Splits the count into decimal digits and maps them to blanked seven-segment codes.
module dbc_seg (
   input  dbc_pkg::count_type count,
   output dbc_pkg::disp_type  disp
);
   import dbc_pkg::*;

   logic [17:0] prod_tens;
   logic [15:0] prod_hund;
   logic [6:0]  quot_tens;
   logic [3:0]  quot_hund;
   logic [10:0] rem_ones;
   logic [6:0]  rem_tens;
   digit_type   d_ones;
   digit_type   d_tens;
   digit_type   d_hund;

   // Reciprocal multiplies: exact for every count below 1024.
   always_comb begin
      prod_tens = 18'(count) * 18'(205);
      prod_hund = 16'(count) * 16'(41);
      quot_tens = prod_tens[17:11];
      quot_hund = prod_hund[15:12];
      rem_ones  = {1'b0, count} - ({4'b0, quot_tens} * 11'(10));
      rem_tens  = quot_tens - ({3'b0, quot_hund} * 7'(10));
      d_ones    = rem_ones[3:0];
      d_tens    = rem_tens[3:0];
      d_hund    = (quot_hund == 4'd10) ? 4'd0 : quot_hund;

      disp.count     = count;
      disp.ones      = digit_code(d_ones);
      disp.tens      = (quot_tens == '0) ? SEG_BLANK : digit_code(d_tens);
      disp.colon     = SEG_BLANK;
      disp.hundreds  = (quot_hund == '0) ? SEG_BLANK : digit_code(d_hund);
      disp.thousands = (count < COUNT_W'(1000)) ? SEG_BLANK : digit_code(4'd1);
   end

endmodule

[sv/debounced_button_counter_display.sv]
// Debounced button counter: eight parallel debounce lanes, a count merge and a display decode.
// Path: an accepted sample updates the lane histories and the count register, and the decoded
// display of that count is then captured in the output register.
// Throughput: one sample per cycle unless the output stalls; count and lane histories feed back.
// The count stage and the output register both hold a beat while the output stalls.
// Reset (synchronous, active high) clears all button histories, the count and both valid flags.
module debounced_button_counter_display (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_button_levels,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dbc_pkg::count_type rsp_count,
   output dbc_pkg::seg_type   rsp_ones_segments,
   output dbc_pkg::seg_type   rsp_tens_segments,
   output dbc_pkg::seg_type   rsp_colon_segments,
   output dbc_pkg::seg_type   rsp_hundreds_segments,
   output dbc_pkg::seg_type   rsp_thousands_segments
);
   import dbc_pkg::*;

   logic      accept;
   logic      out_load;
   logic      cnt_valid_ff;
   logic      cnt_valid_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   fire_type  fires;
   count_type count;
   disp_type  disp;
   disp_type  disp_ff;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !cnt_valid_ff || out_load;
   assign accept    = req_valid && req_ready;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      dbc_lane u_lane (
         .clock (clock),
         .reset (reset),
         .load  (accept),
         .level (req_button_levels[i]),
         .fire  (fires[i])
      );
   end

   dbc_merge u_merge (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .fires (fires),
      .count (count)
   );

   dbc_seg u_seg (
      .count (count),
      .disp  (disp)
   );

   always_comb begin
      cnt_valid_in = accept || (cnt_valid_ff && !out_load);
      out_valid_in = out_load ? cnt_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_valid_ff <= cnt_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The output beat only moves forward when the downstream slot is free.
   always_ff @(posedge clock) begin
      if (out_load && cnt_valid_ff) begin
         disp_ff <= disp;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_count              = disp_ff.count;
   assign rsp_ones_segments      = disp_ff.ones;
   assign rsp_tens_segments      = disp_ff.tens;
   assign rsp_colon_segments     = disp_ff.colon;
   assign rsp_hundreds_segments  = disp_ff.hundreds;
   assign rsp_thousands_segments = disp_ff.thousands;

endmodule
